[sv/fpc_pkg.sv]
package fpc_pkg;

  // plane register layout
  localparam int NORMAL_BITS = 14;
  localparam int OFFSET_BITS = 22;
  localparam int PLANE_BITS  = 64;
  localparam int NX_LSB      = 0;
  localparam int NY_LSB      = NORMAL_BITS;
  localparam int NZ_LSB      = 2 * NORMAL_BITS;
  localparam int D_LSB       = 3 * NORMAL_BITS;

  // normal is Q1.12, coordinates carry 10 fraction bits: distance in 2^-22
  localparam int FRAC_SHIFT  = 12;

  localparam int EXT_BITS    = 21;
  localparam int FUNC_BITS   = 2;

  // writable plane registers, config index space
  localparam int PLANE_REGS     = 6;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [FUNC_BITS-1:0] FUNC_CUBE   = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_SPHERE = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_POINT  = 2'd2;

  typedef enum logic [1:0] {
    VERDICT_IN    = 2'd0,
    VERDICT_CROSS = 2'd1,
    VERDICT_OUT   = 2'd2
  } verdict_t;

  // per-stage load enables handed to the plane units
  typedef struct packed {
    logic ld2;
    logic ld3;
  } stage_ctrl_t;

endpackage

[sv/fpc_plane_unit.sv]
module fpc_plane_unit #(
  parameter int SUM_BITS = 23
) (
  input  logic                            clk,
  input  fpc_pkg::stage_ctrl_t            ctrl,
  input  logic [fpc_pkg::PLANE_BITS-1:0]  plane,
  input  logic                            cube,
  input  logic                            sphere,
  input  logic signed [SUM_BITS-1:0]      lo_x,
  input  logic signed [SUM_BITS-1:0]      lo_y,
  input  logic signed [SUM_BITS-1:0]      lo_z,
  input  logic signed [SUM_BITS-1:0]      hi_x,
  input  logic signed [SUM_BITS-1:0]      hi_y,
  input  logic signed [SUM_BITS-1:0]      hi_z,
  input  logic [fpc_pkg::EXT_BITS-1:0]    extent,
  output logic                            far_neg,
  output logic                            near_neg
);

  localparam int PROD_BITS = fpc_pkg::NORMAL_BITS + SUM_BITS;
  localparam int BIAS_BITS = fpc_pkg::OFFSET_BITS + fpc_pkg::FRAC_SHIFT + 1;
  localparam int DIST_BITS = ((PROD_BITS + 2 > BIAS_BITS) ? PROD_BITS + 2 : BIAS_BITS) + 1;

  logic signed [fpc_pkg::NORMAL_BITS-1:0] n   [3];
  logic signed [SUM_BITS-1:0]             lo  [3];
  logic signed [SUM_BITS-1:0]             hi  [3];
  logic signed [fpc_pkg::OFFSET_BITS-1:0] d;

  logic signed [PROD_BITS-1:0] far_p_nxt  [3];
  logic signed [PROD_BITS-1:0] near_p_nxt [3];
  logic signed [PROD_BITS-1:0] far_p_r    [3];
  logic signed [PROD_BITS-1:0] near_p_r   [3];
  logic signed [BIAS_BITS-1:0] bias_nxt, bias_r;
  logic signed [DIST_BITS-1:0] far_dist, near_dist;
  logic                        far_neg_r, near_neg_r;

  assign n[0] = signed'(plane[fpc_pkg::NX_LSB +: fpc_pkg::NORMAL_BITS]);
  assign n[1] = signed'(plane[fpc_pkg::NY_LSB +: fpc_pkg::NORMAL_BITS]);
  assign n[2] = signed'(plane[fpc_pkg::NZ_LSB +: fpc_pkg::NORMAL_BITS]);
  assign d    = signed'(plane[fpc_pkg::D_LSB +: fpc_pkg::OFFSET_BITS]);

  assign lo[0] = lo_x;
  assign lo[1] = lo_y;
  assign lo[2] = lo_z;
  assign hi[0] = hi_x;
  assign hi[1] = hi_y;
  assign hi[2] = hi_z;

  // far vertex: max corner where the normal is non-negative; near: the other one.
  // sphere and point use the position for both.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      far_p_nxt[a]  = PROD_BITS'(n[a]) *
                      PROD_BITS'((cube && !n[a][fpc_pkg::NORMAL_BITS-1]) ? hi[a] : lo[a]);
      near_p_nxt[a] = PROD_BITS'(n[a]) *
                      PROD_BITS'((cube && n[a][fpc_pkg::NORMAL_BITS-1]) ? hi[a] : lo[a]);
    end
  end

  // sphere radius folds into the offset, so the test is a sign check
  assign bias_nxt = (BIAS_BITS'(d) <<< fpc_pkg::FRAC_SHIFT) +
                    (sphere ? (BIAS_BITS'(signed'({1'b0, extent})) <<< fpc_pkg::FRAC_SHIFT)
                            : BIAS_BITS'(0));

  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      far_p_r  <= far_p_nxt;
      near_p_r <= near_p_nxt;
      bias_r   <= bias_nxt;
    end
  end

  assign far_dist  = DIST_BITS'(far_p_r[0]) + DIST_BITS'(far_p_r[1]) +
                     DIST_BITS'(far_p_r[2]) + DIST_BITS'(bias_r);
  assign near_dist = DIST_BITS'(near_p_r[0]) + DIST_BITS'(near_p_r[1]) +
                     DIST_BITS'(near_p_r[2]) + DIST_BITS'(bias_r);

  always_ff @(posedge clk) begin
    if (ctrl.ld3) begin
      far_neg_r  <= far_dist[DIST_BITS-1];
      near_neg_r <= near_dist[DIST_BITS-1];
    end
  end

  assign far_neg  = far_neg_r;
  assign near_neg = near_neg_r;

endmodule

[sv/frustum_plane_culling.sv]
// Frustum plane culling: tests cubes, spheres and points against up to
// PLANE_COUNT planes (six writable, index 0..5 = top, bottom, left, right,
// near, far; any further planes stay zero and never reject). Each plane word
// packs normal x/y/z as signed Q1.12 in bits 13:0, 27:14, 41:28 and a signed
// offset with 10 fraction bits in 63:42. Distances are exact, no rounding.
// in_func 0 classifies a cube at (pos, pos+extent) as inside/straddling/
// outside; 1 rejects a sphere (center pos, radius extent); 2 and 3 reject a
// point behind any plane. One query enters per clock and its verdict passes
// the input register, multiply, sum and verdict stages; the pipeline keeps
// full throughput as long as out_stall is low, and a stall only holds stages
// that are occupied, so bubbles are squeezed out. The user writes plane
// registers through cfg_* only while no query is in flight; the block does not
// enforce this. After reset all planes are zero and everything reads inside.
module frustum_plane_culling #(
  parameter int PLANE_COUNT = 6,
  parameter int COORD_BITS  = 22
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // query channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [fpc_pkg::FUNC_BITS-1:0]        in_func,
  input  logic signed [COORD_BITS-1:0]         in_pos_x,
  input  logic signed [COORD_BITS-1:0]         in_pos_y,
  input  logic signed [COORD_BITS-1:0]         in_pos_z,
  input  logic [fpc_pkg::EXT_BITS-1:0]         in_extent,
  // verdict channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_verdict,
  // plane register writes
  input  logic                                 cfg_wr_en,
  input  logic [fpc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [fpc_pkg::PLANE_BITS-1:0]       cfg_data
);

  // coordinate plus extent without overflow
  localparam int SUM_BITS =
    ((COORD_BITS > fpc_pkg::EXT_BITS + 1) ? COORD_BITS : fpc_pkg::EXT_BITS + 1) + 1;

  // ---------------- plane registers ----------------
  logic [fpc_pkg::PLANE_BITS-1:0] plane_w [PLANE_COUNT];

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    if (p < fpc_pkg::PLANE_REGS) begin : g_reg
      logic [fpc_pkg::PLANE_BITS-1:0] plane_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          plane_r <= '0;
        end else if (cfg_wr_en && cfg_index == fpc_pkg::CFG_INDEX_BITS'(p)) begin
          plane_r <= cfg_data;
        end
      end
      assign plane_w[p] = plane_r;
    end else begin : g_zero
      // not writable: zero plane, distance always 0
      assign plane_w[p] = '0;
    end
  end

  // ---------------- pipeline flow control ----------------
  // A stage loads when it is empty or the stage after it loads.
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic ld1, ld2, ld3, ld_o;
  fpc_pkg::stage_ctrl_t ctrl;

  assign ld_o     = !out_valid_r || !out_stall;
  assign ld3      = !v3_r || ld_o;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_stall = !ld1;

  assign ctrl.ld2 = ld2;
  assign ctrl.ld3 = ld3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1)  v1_r        <= in_valid;
      if (ld2)  v2_r        <= v1_r;
      if (ld3)  v3_r        <= v2_r;
      if (ld_o) out_valid_r <= v3_r;
    end
  end

  // ---------------- stage 1: capture, max corner ----------------
  logic                       s1_cube_r, s1_sphere_r;
  logic signed [SUM_BITS-1:0] s1_lo_x_r, s1_lo_y_r, s1_lo_z_r;
  logic signed [SUM_BITS-1:0] s1_hi_x_r, s1_hi_y_r, s1_hi_z_r;
  logic [fpc_pkg::EXT_BITS-1:0] s1_ext_r;
  logic signed [SUM_BITS-1:0] ext_s;

  assign ext_s = SUM_BITS'(signed'({1'b0, in_extent}));

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_cube_r   <= (in_func == fpc_pkg::FUNC_CUBE);
      s1_sphere_r <= (in_func == fpc_pkg::FUNC_SPHERE);
      s1_lo_x_r   <= SUM_BITS'(in_pos_x);
      s1_lo_y_r   <= SUM_BITS'(in_pos_y);
      s1_lo_z_r   <= SUM_BITS'(in_pos_z);
      s1_hi_x_r   <= SUM_BITS'(in_pos_x) + ext_s;
      s1_hi_y_r   <= SUM_BITS'(in_pos_y) + ext_s;
      s1_hi_z_r   <= SUM_BITS'(in_pos_z) + ext_s;
      s1_ext_r    <= in_extent;
    end
  end

  // cube flag follows the data; planes carry products and sign bits
  logic s2_cube_r, s3_cube_r;

  always_ff @(posedge clk) begin
    if (ld2) s2_cube_r <= s1_cube_r;
    if (ld3) s3_cube_r <= s2_cube_r;
  end

  // ---------------- stages 2-3: per-plane products and distance signs ----------------
  logic [PLANE_COUNT-1:0] far_neg, near_neg;

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_unit
    fpc_plane_unit #(
      .SUM_BITS (SUM_BITS)
    ) u_plane (
      .clk      (clk),
      .ctrl     (ctrl),
      .plane    (plane_w[p]),
      .cube     (s1_cube_r),
      .sphere   (s1_sphere_r),
      .lo_x     (s1_lo_x_r),
      .lo_y     (s1_lo_y_r),
      .lo_z     (s1_lo_z_r),
      .hi_x     (s1_hi_x_r),
      .hi_y     (s1_hi_y_r),
      .hi_z     (s1_hi_z_r),
      .extent   (s1_ext_r),
      .far_neg  (far_neg[p]),
      .near_neg (near_neg[p])
    );
  end

  // ---------------- stage 4: verdict register ----------------
  fpc_pkg::verdict_t verdict_nxt, verdict_r;

  always_comb begin
    if (|far_neg) begin
      verdict_nxt = fpc_pkg::VERDICT_OUT;
    end else if (s3_cube_r && |near_neg) begin
      verdict_nxt = fpc_pkg::VERDICT_CROSS;
    end else begin
      verdict_nxt = fpc_pkg::VERDICT_IN;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_o) verdict_r <= verdict_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

`ifndef ASSERT_OFF
  // an accepted query always lands in stage 1
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted query lost before stage 1");

  // input backpressure only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_valid_r))
    else $error("input stalled with a free stage");

  // sphere and point queries never straddle
  a_no_cross: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && ld_o && !s3_cube_r) |=> (out_verdict != fpc_pkg::VERDICT_CROSS))
    else $error("straddle verdict on non-cube query");

  // a stage holding data is not overwritten while the next one is blocked
  a_hold_s3: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !ld_o) |=> v3_r)
    else $error("stage 3 dropped while output stalled");
`endif

endmodule

[sim/frustum_cull_checker.sv]
module frustum_cull_checker #(
  parameter int COORD_BITS = 22
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [fpc_pkg::FUNC_BITS-1:0]        in_func,
  input  logic signed [COORD_BITS-1:0]         in_pos_x,
  input  logic signed [COORD_BITS-1:0]         in_pos_y,
  input  logic signed [COORD_BITS-1:0]         in_pos_z,
  input  logic [fpc_pkg::EXT_BITS-1:0]         in_extent,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [1:0]                           out_verdict,
  input  logic                                 cfg_wr_en,
  input  logic [fpc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [fpc_pkg::PLANE_BITS-1:0]       cfg_data,
  output int                                   fail_count,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow plane words; planes past the writable six stay zero and never reject
  logic [fpc_pkg::PLANE_BITS-1:0] plane_word [fpc_pkg::PLANE_REGS];
  fpc_pkg::verdict_t              verdict_q [$];
  fpc_pkg::verdict_t              want;
  int                             fails;

  // exact signed distances in units of 2^-22
  function automatic fpc_pkg::verdict_t cull_verdict(logic [fpc_pkg::FUNC_BITS-1:0] func,
                                                     longint px, longint py, longint pz,
                                                     longint ext);
    logic signed [fpc_pkg::NORMAL_BITS-1:0] nrm;
    logic signed [fpc_pkg::OFFSET_BITS-1:0] ofs;
    longint            nx, ny, nz, d, far_d, near_d, pos_d;
    fpc_pkg::verdict_t v;
    v = fpc_pkg::VERDICT_IN;
    for (int i = 0; i < fpc_pkg::PLANE_REGS; i++) begin
      nrm = plane_word[i][fpc_pkg::NX_LSB +: fpc_pkg::NORMAL_BITS];
      nx  = nrm;
      nrm = plane_word[i][fpc_pkg::NY_LSB +: fpc_pkg::NORMAL_BITS];
      ny  = nrm;
      nrm = plane_word[i][fpc_pkg::NZ_LSB +: fpc_pkg::NORMAL_BITS];
      nz  = nrm;
      ofs = plane_word[i][fpc_pkg::D_LSB +: fpc_pkg::OFFSET_BITS];
      d   = ofs;
      d   = d * (longint'(1) << fpc_pkg::FRAC_SHIFT);
      if (func == fpc_pkg::FUNC_CUBE) begin
        // far vertex along the normal, near vertex against it
        far_d  = nx * ((nx >= 0) ? px + ext : px) + ny * ((ny >= 0) ? py + ext : py) +
                 nz * ((nz >= 0) ? pz + ext : pz) + d;
        near_d = nx * ((nx >= 0) ? px : px + ext) + ny * ((ny >= 0) ? py : py + ext) +
                 nz * ((nz >= 0) ? pz : pz + ext) + d;
        if (far_d < 0) return fpc_pkg::VERDICT_OUT;
        if (near_d < 0) v = fpc_pkg::VERDICT_CROSS;
      end else begin
        pos_d = nx * px + ny * py + nz * pz + d;
        if (func == fpc_pkg::FUNC_SPHERE) begin
          if (pos_d < -(ext * (longint'(1) << fpc_pkg::FRAC_SHIFT)))
            return fpc_pkg::VERDICT_OUT;
        end else if (pos_d < 0) begin
          // point test, also taken by the unused func code
          return fpc_pkg::VERDICT_OUT;
        end
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fpc_pkg::PLANE_REGS; i++) plane_word[i] = '0;
      verdict_q.delete();
    end else begin
      if (cfg_wr_en && cfg_index < fpc_pkg::PLANE_REGS) plane_word[cfg_index] = cfg_data;
      if (in_valid && !in_stall)
        verdict_q.push_back(cull_verdict(in_func, longint'(in_pos_x), longint'(in_pos_y),
                                         longint'(in_pos_z), longint'(in_extent)));
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict transfer with no query outstanding: expected none, got %0d",
                   $time, out_verdict);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want) begin
            $display("%0t: verdict mismatch: expected %0d, got %0d", $time, want, out_verdict);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= verdict_q.size();
  end

endmodule

[sim/tb_frustum_plane_culling.sv]
module tb_frustum_plane_culling;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS  = 22;
  localparam int UNIT        = 4096;      // 1.0 in Q1.12
  localparam int BOX_HALF    = 102400;    // 100.0 with 10 fraction bits
  localparam int NRM_MAX     = 8191;
  localparam int NRM_MIN     = -8192;
  localparam int OFS_MAX     = 2097151;
  localparam int OFS_MIN     = -2097152;
  localparam int COORD_MAX   = 2097151;
  localparam int COORD_MIN   = -2097152;
  localparam int EXT_MAX     = 2097151;
  localparam int HOLD_CYCLES = 80;        // long receiver hold-off

  // func code the block treats as a point test
  localparam logic [fpc_pkg::FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

  // plane register indexes; the last two are outside the writable set
  typedef enum logic [fpc_pkg::CFG_INDEX_BITS-1:0] {
    PLANE_TOP, PLANE_BOTTOM, PLANE_LEFT, PLANE_RIGHT, PLANE_NEAR, PLANE_FAR,
    PLANE_SPARE6, PLANE_SPARE7
  } plane_idx_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_stall;
  logic [fpc_pkg::FUNC_BITS-1:0]        in_func;
  logic signed [COORD_BITS-1:0]         in_pos_x;
  logic signed [COORD_BITS-1:0]         in_pos_y;
  logic signed [COORD_BITS-1:0]         in_pos_z;
  logic [fpc_pkg::EXT_BITS-1:0]         in_extent;
  logic                                 out_valid;
  logic                                 out_stall;
  logic [1:0]                           out_verdict;
  logic                                 cfg_wr_en;
  logic [fpc_pkg::CFG_INDEX_BITS-1:0]   cfg_index;
  logic [fpc_pkg::PLANE_BITS-1:0]       cfg_data;
  int                                   fail_count;
  int                                   pending;

  // sender burst bookkeeping and the one-shot receiver hold-off
  int   burst_left;
  logic hold_off;
  logic hold_done;
  int   stall_pct;
  int   stall_left;
  int   phase_half;

  frustum_plane_culling #(
    .PLANE_COUNT (6),
    .COORD_BITS  (COORD_BITS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_pos_z    (in_pos_z),
    .in_extent   (in_extent),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_verdict (out_verdict),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  frustum_cull_checker #(
    .COORD_BITS  (COORD_BITS)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_pos_z    (in_pos_z),
    .in_extent   (in_extent),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_verdict (out_verdict),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // hard stop in case the pipeline hangs
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: stall density is redrawn at random, from none to heavy. Once
  // hold_off is raised it holds off in one unbroken stretch, counted here,
  // so the pipe fills and pushes back on the sender.
  initial begin
    out_stall  = 1'b0;
    hold_done  = 1'b0;
    stall_pct  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (stall_left == 0) begin
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 20;
            3:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          stall_left = $urandom_range(16, 128);
        end
        stall_left--;
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // plane word: offset on top, then normal z, y, x
  function automatic logic [fpc_pkg::PLANE_BITS-1:0] pack_plane(int nx, int ny, int nz, int d);
    return {d[fpc_pkg::OFFSET_BITS-1:0], nz[fpc_pkg::NORMAL_BITS-1:0],
            ny[fpc_pkg::NORMAL_BITS-1:0], nx[fpc_pkg::NORMAL_BITS-1:0]};
  endfunction

  function automatic int jitter(int j);
    return (j == 0) ? 0 : int'($urandom_range(0, 2 * j)) - j;
  endfunction

  function automatic int rand_coord(int span);
    case ($urandom_range(0, 15))
      0:       return int'($urandom_range(0, 4194303)) + COORD_MIN;
      1:       return COORD_MAX;
      2:       return COORD_MIN;
      default: return int'($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic int rand_extent(int span);
    case ($urandom_range(0, 15))
      0:       return int'($urandom_range(0, EXT_MAX));
      1:       return EXT_MAX;
      2:       return 0;
      default: return int'($urandom_range(0, span));
    endcase
  endfunction

  task automatic write_plane(plane_idx_t idx, logic [fpc_pkg::PLANE_BITS-1:0] word);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = word;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Present one query and hold it until the transfer. valid stays high
  // into the next query while the burst lasts; a gap drops it.
  task automatic send_query(logic [fpc_pkg::FUNC_BITS-1:0] f, int x, int y, int z, int e);
    int gap;
    @(negedge clk);
    in_valid  = 1'b1;
    in_func   = f;
    in_pos_x  = x[COORD_BITS-1:0];
    in_pos_y  = y[COORD_BITS-1:0];
    in_pos_z  = z[COORD_BITS-1:0];
    in_extent = e[fpc_pkg::EXT_BITS-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic rand_query(int span);
    logic [fpc_pkg::FUNC_BITS-1:0] f;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: f = fpc_pkg::FUNC_CUBE;
      4, 5, 6:    f = fpc_pkg::FUNC_SPHERE;
      7, 8:       f = fpc_pkg::FUNC_POINT;
      default:    f = FUNC_UNUSED;
    endcase
    send_query(f, rand_coord(span), rand_coord(span), rand_coord(span), rand_extent(span));
  endtask

  // drop valid so a transferred query is not offered again, then wait for
  // every verdict
  task automatic wait_drained();
    if (in_valid) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Six planes around the origin: slant tilts the side planes along z,
  // jit perturbs every normal component and offset.
  task automatic set_frustum(int half, int slant, int jit);
    write_plane(PLANE_TOP,    pack_plane(jitter(jit), -UNIT + jitter(jit),
                                         slant + jitter(jit), half + jitter(jit)));
    write_plane(PLANE_BOTTOM, pack_plane(jitter(jit), UNIT + jitter(jit),
                                         slant + jitter(jit), half + jitter(jit)));
    write_plane(PLANE_LEFT,   pack_plane(UNIT + jitter(jit), jitter(jit),
                                         slant + jitter(jit), half + jitter(jit)));
    write_plane(PLANE_RIGHT,  pack_plane(-UNIT + jitter(jit), jitter(jit),
                                         slant + jitter(jit), half + jitter(jit)));
    write_plane(PLANE_NEAR,   pack_plane(jitter(jit), jitter(jit),
                                         UNIT + jitter(jit), half + jitter(jit)));
    write_plane(PLANE_FAR,    pack_plane(jitter(jit), jitter(jit),
                                         -UNIT + jitter(jit), half + jitter(jit)));
  endtask

  task automatic set_all_planes(logic [fpc_pkg::PLANE_BITS-1:0] word);
    for (int i = PLANE_TOP; i <= PLANE_FAR; i++) write_plane(plane_idx_t'(i), word);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_func    = fpc_pkg::FUNC_CUBE;
    in_pos_x   = '0;
    in_pos_y   = '0;
    in_pos_z   = '0;
    in_extent  = '0;
    cfg_wr_en  = 1'b0;
    cfg_index  = PLANE_TOP;
    cfg_data   = '0;
    hold_off   = 1'b0;
    burst_left = $urandom_range(1, 12);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // planes still zero after reset: every query lands inside
    send_query(fpc_pkg::FUNC_CUBE, COORD_MAX, COORD_MAX, COORD_MAX, EXT_MAX);
    send_query(fpc_pkg::FUNC_SPHERE, COORD_MIN, COORD_MIN, COORD_MIN, 0);
    send_query(fpc_pkg::FUNC_POINT, COORD_MIN, COORD_MAX, COORD_MIN, EXT_MAX);
    wait_drained();

    // axis-aligned box of half width 100.0; writes past the sixth plane are dropped
    set_frustum(BOX_HALF, 0, 0);
    write_plane(PLANE_SPARE6, '1);
    write_plane(PLANE_SPARE7, pack_plane(UNIT, UNIT, UNIT, OFS_MIN));

    // cubes: inside, touching a face, straddling, outside, degenerate, huge
    send_query(fpc_pkg::FUNC_CUBE, -10240, -10240, -10240, 20480);
    send_query(fpc_pkg::FUNC_CUBE, 81920, 0, 0, 20480);
    send_query(fpc_pkg::FUNC_CUBE, 92160, 0, 0, 20480);
    send_query(fpc_pkg::FUNC_CUBE, 112640, 0, 0, 1024);
    send_query(fpc_pkg::FUNC_CUBE, 0, 0, 0, 0);
    send_query(fpc_pkg::FUNC_CUBE, COORD_MIN, COORD_MIN, COORD_MIN, EXT_MAX);
    send_query(fpc_pkg::FUNC_CUBE, COORD_MAX, COORD_MAX, COORD_MAX, EXT_MAX);
    // spheres: partly out, exactly one radius out, fully out, zero radius
    send_query(fpc_pkg::FUNC_SPHERE, 110000, 0, 0, 10240);
    send_query(fpc_pkg::FUNC_SPHERE, 112640, 0, 0, 10240);
    send_query(fpc_pkg::FUNC_SPHERE, 120000, 0, 0, 10240);
    send_query(fpc_pkg::FUNC_SPHERE, 0, 0, BOX_HALF + 1, 0);
    send_query(fpc_pkg::FUNC_SPHERE, COORD_MIN, COORD_MIN, COORD_MIN, EXT_MAX);
    // points: extent ignored, on a plane, one step behind, range corner
    send_query(fpc_pkg::FUNC_POINT, 0, 0, 0, EXT_MAX);
    send_query(fpc_pkg::FUNC_POINT, 0, -BOX_HALF, 0, 0);
    send_query(fpc_pkg::FUNC_POINT, 0, -BOX_HALF - 1, 0, 0);
    send_query(fpc_pkg::FUNC_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0);
    // unused func code behaves as a point test
    send_query(FUNC_UNUSED, 0, 0, 0, 0);
    send_query(FUNC_UNUSED, 0, 0, COORD_MIN, 7);
    wait_drained();

    // box again under random traffic, opening with the long receiver hold-off
    // while the sender keeps offering back to back
    burst_left = 1000;
    hold_off   = 1'b1;
    repeat (40) rand_query(2 * BOX_HALF);
    hold_off   = 1'b0;
    burst_left = 0;
    repeat (80) rand_query(2 * BOX_HALF);
    wait_drained();

    // skewed, perturbed frustum of random size
    phase_half = $urandom_range(2048, 500000);
    set_frustum(phase_half, jitter(2048), 1500);
    repeat (120) rand_query(2 * phase_half);
    wait_drained();

    // extreme plane words, both signs
    set_all_planes(pack_plane(NRM_MAX, NRM_MAX, NRM_MAX, OFS_MAX));
    repeat (60) rand_query(1000000);
    wait_drained();
    set_all_planes(pack_plane(NRM_MIN, NRM_MIN, NRM_MIN, OFS_MIN));
    write_plane(PLANE_SPARE7, '0);
    repeat (60) rand_query(1000000);
    wait_drained();

    // arbitrary plane words
    for (int i = PLANE_TOP; i <= PLANE_FAR; i++)
      write_plane(plane_idx_t'(i), {$urandom, $urandom});
    repeat (80) rand_query(1000000);
    wait_drained();

    // small steep frustum; the sender pauses halfway until all verdicts are back
    set_frustum(4096, 3000, 500);
    repeat (55) rand_query(8192);
    wait_drained();
    repeat (55) rand_query(8192);
    wait_drained();

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
